// ===== hdl/mpe_pkg.sv =====
`default_nettype none
package mpe_pkg;
  localparam int unsigned MaxTermsDef = 64;
  localparam int unsigned MaxExpDef = 7;
  localparam logic [1:0] RegNumDims = 2'd0;
  localparam logic [1:0] RegNumTerms = 2'd1;

  typedef struct packed {
    logic              mode;
    logic [5:0]        term_index;
    logic signed [31:0] coefficient;
    logic [2:0]        exp_x;
    logic [2:0]        exp_y;
    logic [2:0]        exp_z;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               is_eval;
    logic [5:0]         term_index;
    logic signed [31:0] coefficient;
    logic [8:0]         exps;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } cmd_t;
endpackage
`default_nettype wire

// ===== hdl/mpe_front.sv =====
`default_nettype none
module mpe_front import mpe_pkg::*; #(
  parameter int unsigned MaxExp = MaxExpDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_i,
  output logic          cmd_valid_o,
  input  wire logic     cmd_ready_i,
  output cmd_t          cmd_o
);
  // two-entry queue towards the back end
  cmd_t q_mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t c;

  function automatic logic [2:0] clampe(input logic [2:0] e);
    clampe = (32'(e) > MaxExp) ? 3'(MaxExp) : e;
  endfunction

  always_comb begin
    c.is_eval = in_i.mode;
    c.term_index = in_i.term_index;
    c.coefficient = in_i.coefficient;
    c.exps = {clampe(in_i.exp_z), clampe(in_i.exp_y), clampe(in_i.exp_x)};
    c.coord_x = in_i.coord_x;
    c.coord_y = in_i.coord_y;
    c.coord_z = in_i.coord_z;
  end

  assign full = cnt_q == 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o = q_mem_q[rp_q];

  wire logic wr = push && !full;
  wire logic rd = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) q_mem_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/mpe_back.sv =====
`default_nettype none
module mpe_back import mpe_pkg::*; #(
  parameter int unsigned MaxTerms = MaxTermsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] num_dims_i,
  input  wire logic [6:0] num_terms_i,
  input  wire logic       cmd_valid_i,
  output logic            cmd_ready_o,
  input  wire cmd_t       cmd_i,
  output logic            empty,
  input  wire logic       pop,
  output out_item_t       out_o
);
  localparam int unsigned Aw = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam logic [2:0] SIdle = 3'd0, SRead = 3'd1, SPow = 3'd2, SCoef = 3'd3,
                         SAcc = 3'd4, SDone = 3'd5;

  logic [31:0] coef_mem [MaxTerms];
  logic [8:0]  exp_mem  [MaxTerms];
  logic [31:0] rd_coef_q;
  logic [8:0]  rd_exp_q;

  logic [2:0]  st_q;
  logic [10:0] t_q, n_q;
  logic [1:0]  d_q;
  logic [2:0]  k_q;
  logic signed [32:0] p_q;
  logic signed [63:0] term_q, acc_q;
  logic        sat_q, out_v_q;
  out_item_t   res_q;
  logic signed [15:0] cx_q, cy_q, cz_q;
  logic [1:0]  dims_q;

  wire logic take = cmd_valid_i && cmd_ready_o;
  wire logic [Aw-1:0] wr_idx = Aw'(cmd_i.term_index);
  assign cmd_ready_o = (st_q == SIdle);
  assign empty = !out_v_q;
  assign out_o = res_q;

  always_ff @(posedge clk_i) begin
    if (take && !cmd_i.is_eval && 32'(cmd_i.term_index) < MaxTerms) begin
      coef_mem[wr_idx] <= cmd_i.coefficient;
      exp_mem[wr_idx] <= cmd_i.exps;
    end
    rd_coef_q <= coef_mem[t_q[Aw-1:0]];
    rd_exp_q <= exp_mem[t_q[Aw-1:0]];
  end

  logic [2:0] e_cur;
  logic signed [15:0] c_cur;
  logic signed [48:0] pm;
  logic signed [64:0] cm;
  logic signed [64:0] sum;
  always_comb begin
    unique case (d_q)
      2'd0: begin e_cur = rd_exp_q[2:0]; c_cur = cx_q; end
      2'd1: begin e_cur = rd_exp_q[5:3]; c_cur = cy_q; end
      default: begin e_cur = rd_exp_q[8:6]; c_cur = cz_q; end
    endcase
    pm = p_q * c_cur;
    cm = $signed(rd_coef_q) * p_q;
    sum = {acc_q[63], acc_q} + {term_q[63], term_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; out_v_q <= 1'b0; t_q <= '0; n_q <= '0; d_q <= '0; k_q <= '0;
      p_q <= '0; term_q <= '0; acc_q <= '0; sat_q <= 1'b0; res_q <= '0;
      cx_q <= '0; cy_q <= '0; cz_q <= '0; dims_q <= '0;
    end else begin
      if (out_v_q && pop) out_v_q <= 1'b0;
      unique case (st_q)
        SIdle: if (take && cmd_i.is_eval) begin
          cx_q <= cmd_i.coord_x; cy_q <= cmd_i.coord_y; cz_q <= cmd_i.coord_z;
          dims_q <= num_dims_i;
          n_q <= (32'(num_terms_i) > MaxTerms) ? 11'(MaxTerms) : 11'(num_terms_i);
          t_q <= '0; acc_q <= '0; sat_q <= 1'b0;
          st_q <= (num_terms_i == 7'd0) ? SDone : SRead;
        end
        SRead: begin
          p_q <= 33'sh080000000; d_q <= '0; k_q <= '0; st_q <= SPow;
        end
        SPow: begin
          if (d_q >= dims_q || d_q == 2'd3) st_q <= SCoef;
          else if (k_q >= e_cur) begin d_q <= d_q + 2'd1; k_q <= '0; end
          else begin p_q <= 33'(pm >>> 15); k_q <= k_q + 3'd1; end
        end
        SCoef: begin term_q <= 64'(cm >>> 15); st_q <= SAcc; end
        SAcc: begin
          if (sum[64] != sum[63]) begin
            acc_q <= sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            sat_q <= 1'b1;
          end else acc_q <= sum[63:0];
          t_q <= t_q + 11'd1;
          st_q <= (t_q + 11'd1 >= n_q) ? SDone : SRead;
        end
        SDone: if (!out_v_q) begin
          out_v_q <= 1'b1;
          res_q.value <= acc_q;
          res_q.saturated <= sat_q;
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/multivariate_poly_evaluator_core.sv =====
`default_nettype none
// Write items reach the term table when the back end takes them, which it does only while idle;
// evaluations step through SRead, SPow, SCoef and SAcc for each active term, then SDone;
// num_terms 0 goes straight to SDone.
// Throughput: one evaluation at a time; power products iterate one multiply a cycle.
// Reset: asynchronous active low; registers return to num_dims 1, num_terms 1,
// queues empty. Term table contents are undefined until written.
module multivariate_poly_evaluator_core import mpe_pkg::*; #(
  parameter int unsigned MaxTerms = MaxTermsDef,
  parameter int unsigned MaxExp = MaxExpDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire in_item_t   in_i,
  output logic            empty,
  input  wire logic       pop,
  output out_item_t       out_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  logic [1:0] dims_q;
  logic [6:0] terms_q;
  logic cv, cr;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 2'd1; terms_q <= 7'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegNumDims) dims_q <= cfg_data_i[1:0];
      else if (cfg_index_i == RegNumTerms) terms_q <= cfg_data_i[6:0];
    end
  end

  mpe_front #(.MaxExp(MaxExp)) u_front (
    .clk_i, .rst_ni, .push, .full, .in_i,
    .cmd_valid_o(cv), .cmd_ready_i(cr), .cmd_o(cmd)
  );
  mpe_back #(.MaxTerms(MaxTerms)) u_back (
    .clk_i, .rst_ni, .num_dims_i(dims_q), .num_terms_i(terms_q),
    .cmd_valid_i(cv), .cmd_ready_o(cr), .cmd_i(cmd), .empty, .pop, .out_o
  );
endmodule
`default_nettype wire

// ===== tb/poly_eval_checker.sv =====
`timescale 1ns / 1ps
module poly_eval_checker import mpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  in_item_t    in_i,
  input  logic        empty,
  input  logic        pop,
  input  out_item_t   out_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  logic signed [31:0] coefs [64];
  logic [8:0]         exps [64];
  logic [1:0]         dims_q;
  logic [6:0]         terms_q;
  out_item_t          expected_values [$];

  function automatic out_item_t eval_poly(in_item_t it);
    out_item_t          r;
    longint             coord [3];
    longint             prod;
    longint             term;
    logic signed [64:0] sum;
    longint             acc;
    int                 n;
    int                 e;
    acc = 0;
    r.saturated = 1'b0;
    coord[0] = it.coord_x;
    coord[1] = it.coord_y;
    coord[2] = it.coord_z;
    n = (terms_q > 64) ? 64 : terms_q;
    for (int t = 0; t < n; t++) begin
      prod = 64'sd1 <<< 31;
      for (int d = 0; d < 3 && d < dims_q; d++) begin
        e = exps[t][3*d +: 3];
        for (int k = 0; k < e; k++) prod = (prod * coord[d]) >>> 15;
      end
      term = (longint'(coefs[t]) * prod) >>> 15;
      sum = 65'(acc) + 65'(term);
      if (sum > 65'sh0_7fff_ffff_ffff_ffff) begin
        acc = 64'sh7fff_ffff_ffff_ffff;
        r.saturated = 1'b1;
      end else if (sum < -65'sh0_8000_0000_0000_0000) begin
        acc = 64'sh8000_0000_0000_0000;
        r.saturated = 1'b1;
      end else begin
        acc = sum[63:0];
      end
    end
    r.value = acc;
    return r;
  endfunction

  assign pending_o = expected_values.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      dims_q <= 2'd1;
      terms_q <= 7'd1;
      fail_count_o <= 0;
      expected_values.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegNumDims) dims_q <= cfg_data_i[1:0];
        else if (cfg_index_i == RegNumTerms) terms_q <= cfg_data_i[6:0];
      end
      if (push && !full) begin
        if (in_i.mode) begin
          expected_values.push_back(eval_poly(in_i));
        end else begin
          coefs[in_i.term_index] <= in_i.coefficient;
          exps[in_i.term_index] <= {in_i.exp_z, in_i.exp_y, in_i.exp_x};
        end
      end
      if (pop && !empty) begin
        if (expected_values.size() == 0) begin
          $error("result transfer with no result expected");
          errs++;
        end else begin
          want = expected_values.pop_front();
          if (out_o.value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, out_o.value);
            errs++;
          end
          if (out_o.saturated !== want.saturated) begin
            $error("saturated: expected %b, actual %b", want.saturated, out_o.saturated);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

// ===== tb/tb_multivariate_poly_evaluator_core.sv =====
`timescale 1ns / 1ps
module tb_multivariate_poly_evaluator_core;
  import mpe_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_item_t    in_item;
  logic        empty;
  logic        pop;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  int          quiet_cycles;
  bit          gaps_on;
  bit          written [64];

  multivariate_poly_evaluator_core dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full), .in_i(in_item),
    .empty(empty), .pop(pop), .out_o(out_item), .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  poly_eval_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full), .in_i(in_item),
    .empty(empty), .pop(pop), .out_o(out_item), .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    return gaps_on ? $urandom_range(0, 13) : 0;
  endfunction

  function automatic int written_prefix();
    int k;
    k = 0;
    while (k < 64 && written[k]) k++;
    return k;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    in_item = it;
    do @(posedge clk); while (full);
    if (!it.mode) written[it.term_index] = 1'b1;
    @(negedge clk);
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    return it;
  endfunction

  task automatic write_term(int idx, logic [31:0] coef, logic [2:0] ex, logic [2:0] ey,
                            logic [2:0] ez);
    in_item_t it;
    it = noise_item();
    it.mode = 1'b0;
    it.term_index = 6'(idx);
    it.coefficient = coef;
    it.exp_x = ex;
    it.exp_y = ey;
    it.exp_z = ez;
    send_item(it);
  endtask

  task automatic eval_at(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_item_t it;
    it = noise_item();
    it.mode = 1'b1;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    send_item(it);
  endtask

  task automatic drain();
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int pops_gap;
    push = 1'b0;
    in_item = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegNumDims;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    forever begin
      pops_gap = gap_len();
      pop = 1'b0;
      repeat (pops_gap) @(negedge clk);
      pop = 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int items;
    int n_phase;
    int k;
    int idx;
    quiet_cycles = 0;
    gaps_on = 1'b1;
    @(posedge rst_n);
    @(negedge clk);

    write_term(0, 32'h7fff_ffff, 3'd7, 3'd7, 3'd7);
    eval_at(16'h8000, 16'h7fff, 16'h0000);
    eval_at(16'h7fff, 16'h8000, 16'h8000);
    eval_at(16'h0000, 16'h0000, 16'h0000);
    write_term(1, 32'h8000_0000, 3'd0, 3'd0, 3'd0);
    write_term(2, 32'h0000_0001, 3'd7, 3'd0, 3'd7);
    write_term(3, 32'hffff_ffff, 3'd1, 3'd2, 3'd3);
    write_reg(RegNumDims, 32'd3);
    write_reg(RegNumTerms, 32'd4);
    eval_at(16'h8000, 16'h8000, 16'h8000);
    eval_at(16'h7fff, 16'h7fff, 16'h7fff);
    eval_at(16'hffff, 16'h8000, 16'h7fff);
    write_reg(RegNumDims, 32'd0);
    eval_at(16'h1234, 16'h8000, 16'h7fff);
    write_reg(RegNumTerms, 32'd0);
    eval_at(16'h8000, 16'h8000, 16'h8000);
    write_reg(RegNumDims, 32'd2);
    write_reg(RegNumTerms, 32'd1);
    eval_at(16'h8000, 16'h4000, 16'h7fff);

    items = 0;
    while (items < 450) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      k = written_prefix();
      if (k == 64) begin
        case ($urandom_range(0, 4))
          0: write_reg(RegNumTerms, 32'd64);
          1: write_reg(RegNumTerms, 32'd127);
          2: write_reg(RegNumTerms, 32'($urandom_range(65, 127)));
          default: write_reg(RegNumTerms, 32'($urandom_range(0, 64)));
        endcase
      end else begin
        write_reg(RegNumTerms, 32'($urandom_range(0, k)));
      end
      write_reg(RegNumDims, 32'($urandom_range(0, 3)));
      n_phase = $urandom_range(10, 40);
      for (int i = 0; i < n_phase; i++) begin
        if ($urandom_range(0, 9) < 4) begin
          eval_at(pick_coord(), pick_coord(), pick_coord());
        end else begin
          k = written_prefix();
          idx = (k < 64 && $urandom_range(0, 1)) ? k : $urandom_range(0, 63);
          case ($urandom_range(0, 3))
            0: write_term(idx, 32'h7fff_ffff, 3'($urandom), 3'($urandom), 3'($urandom));
            1: write_term(idx, 32'h8000_0000, 3'($urandom), 3'($urandom), 3'($urandom));
            default: write_term(idx, $urandom, 3'($urandom), 3'($urandom), 3'($urandom));
          endcase
        end
        items++;
      end
    end

    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/mpe_pkg.sv
hdl/mpe_front.sv
hdl/mpe_back.sv
hdl/multivariate_poly_evaluator_core.sv
tb/poly_eval_checker.sv
tb/tb_multivariate_poly_evaluator_core.sv
